// File: hw/rtl/tsfd_pkg.sv
package tsfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned WORD_W    = 8 * FRAME_LEN;

    localparam logic [7:0] IDLE_ACK     = 8'h4D;
    localparam logic [7:0] VERSION_HEAD = 8'h80;

    // Last byte position of a frame
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    // Input commands
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_VERSION = 2'd1;
    localparam logic [1:0] CMD_IDLE    = 2'd2;

    // Result kinds, also used as job type in the queue
    localparam logic [1:0] KIND_POS     = 2'd0;
    localparam logic [1:0] KIND_VERSION = 2'd1;
    localparam logic [1:0] KIND_IDLE    = 2'd2;

    // Register map (word index)
    localparam logic [1:0] REG_LOCK   = 2'd0;
    localparam logic [1:0] REG_XLIMIT = 2'd1;
    localparam logic [1:0] REG_YLIMIT = 2'd2;

    localparam logic [15:0] XLIMIT_RST = 16'd6144;
    localparam logic [15:0] YLIMIT_RST = 16'd8192;

    // Job queue
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    // One job from front to back: type plus the seven frame bytes
    typedef struct packed {
        logic [1:0]        jtype;
        logic [WORD_W-1:0] frame;
    } job_t;

    // Coordinate limits seen by the back end
    typedef struct packed {
        logic [15:0] x_limit;
        logic [15:0] y_limit;
    } limits_t;

endpackage

// File: hw/rtl/tsfd_front.sv
module tsfd_front
    import tsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] command,
    input  logic [7:0] rx_byte,
    input  logic       lock_enable,
    output logic       push,
    output job_t       push_job
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ver_pend_reg, ver_pend_next;
    logic             idle_wait_reg, idle_wait_next;
    logic [7:0]       frame_reg [0:FRAME_LEN-2];
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    // Framing and command decode
    always_comb
    begin
        idx_next       = idx_reg;
        ver_pend_next  = ver_pend_reg;
        idle_wait_next = idle_wait_reg;
        wr_en          = 1'b0;
        wr_idx         = idx_reg;
        push           = 1'b0;
        push_job.jtype = KIND_POS;
        push_job.frame = {frame_reg[0], frame_reg[1], frame_reg[2], frame_reg[3],
                          frame_reg[4], frame_reg[5], rx_byte};
        if (accept)
        begin
            unique case (command)
                CMD_VERSION: ver_pend_next = 1'b1;
                CMD_IDLE:    idle_wait_next = 1'b1;
                CMD_BYTE:
                begin
                    if (!lock_enable)
                    begin
                        if (idle_wait_reg && rx_byte == IDLE_ACK)
                        begin
                            idle_wait_next = 1'b0;
                            push           = 1'b1;
                            push_job.jtype = KIND_IDLE;
                        end
                        else if (rx_byte[7])
                        begin
                            // start byte opens a new frame wherever we are
                            wr_en    = 1'b1;
                            wr_idx   = '0;
                            idx_next = IDX_W'(1);
                        end
                        else if (idx_reg == LAST_IDX)
                        begin
                            // last byte completes the frame
                            idx_next = '0;
                            push     = 1'b1;
                            if (ver_pend_reg && frame_reg[0] == VERSION_HEAD)
                            begin
                                ver_pend_next  = 1'b0;
                                push_job.jtype = KIND_VERSION;
                            end
                        end
                        else if (idx_reg != '0)
                        begin
                            wr_en    = 1'b1;
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            ver_pend_reg  <= 1'b0;
            idle_wait_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            ver_pend_reg  <= ver_pend_next;
            idle_wait_reg <= idle_wait_next;
        end
    end

    // Frame byte storage, last byte is taken live
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_LEN - 1; i++)
        begin
            if (wr_en && wr_idx == IDX_W'(i))
            begin
                frame_reg[i] <= rx_byte;
            end
        end
    end

endmodule

// File: hw/rtl/tsfd_queue.sv
module tsfd_queue
    import tsfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              entry_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = entry_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/tsfd_back.sv
module tsfd_back
    import tsfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  job_t          head_job,
    output logic          pop,
    input  limits_t       limits,
    output logic          result_valid,
    input  logic          result_ready,
    output logic [1:0]    kind,
    output logic          touching,
    output logic [15:0]   x_pos,
    output logic [15:0]   y_pos,
    output logic [9:0]    pressure,
    output logic [WORD_W-1:0] version_word
);

    logic [7:0]  b0, b1, b2, b3, b4, b5, b6;
    logic [15:0] raw_x, raw_y;
    logic [9:0]  pres;
    logic        in_range, emit;
    logic        touch_val;
    logic        pen_reg, pen_next;
    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic        touch_reg;
    logic [15:0] x_reg, y_reg;
    logic [9:0]  pres_reg;
    logic [WORD_W-1:0] word_reg;

    assign {b0, b1, b2, b3, b4, b5, b6} = head_job.frame;

    // Unpack raw fields, bit fields overlap on purpose
    assign raw_x = {b1[6:0], 9'b0} | {6'b0, b2, 2'b0} | {13'b0, b6[7:5]};
    assign raw_y = {b3[6:0], 9'b0} | {6'b0, b4, 2'b0} | {14'b0, b6[4:3]};
    assign pres  = {2'b0, b5} | {b6[2:0], 7'b0};
    assign in_range = (raw_x <= limits.x_limit) && (raw_y <= limits.y_limit);

    // Output register frees up when empty or being taken
    assign pop = head_valid && (!valid_reg || result_ready);

    // Report rules
    always_comb
    begin
        emit      = 1'b0;
        touch_val = 1'b0;
        pen_next  = pen_reg;
        unique case (head_job.jtype)
            KIND_VERSION: emit = 1'b1;
            KIND_IDLE:    emit = 1'b1;
            KIND_POS:
            begin
                if (in_range)
                begin
                    if (b0[0] && pres != '0)
                    begin
                        emit      = 1'b1;
                        touch_val = 1'b1;
                        pen_next  = 1'b0;
                    end
                    else if (!b0[0] && pres == '0)
                    begin
                        emit = 1'b1;
                    end
                    else if (b0[0] && !pen_reg)
                    begin
                        emit     = 1'b1;
                        pen_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (!pop)
        begin
            pen_next = pen_reg;
        end
    end

    always_comb
    begin
        if (pop)
        begin
            valid_next = emit;
        end
        else
        begin
            valid_next = valid_reg && !result_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pen_reg   <= pen_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= head_job.jtype;
            touch_reg <= touch_val;
            if (head_job.jtype == KIND_POS)
            begin
                x_reg    <= limits.x_limit - raw_x;
                y_reg    <= limits.y_limit - raw_y;
                pres_reg <= touch_val ? pres : '0;
            end
            else
            begin
                x_reg    <= '0;
                y_reg    <= '0;
                pres_reg <= '0;
            end
            word_reg <= (head_job.jtype == KIND_VERSION) ? head_job.frame : '0;
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign touching     = touch_reg;
    assign x_pos        = x_reg;
    assign y_pos        = y_reg;
    assign pressure     = pres_reg;
    assign version_word = word_reg;

endmodule

// File: hw/rtl/touch_serial_frame_decoder.sv
// A word that completes a report enters the job queue at the accepting edge and
// reaches the output register once that register is empty or being taken.
// Throughput: one word per cycle; a two-entry job queue decouples framing from
// report decode, so the input stalls only when the queue is full.
// Reset (rst_n low, asynchronous): framing index, flags, queue and output valid
// clear; lock off, x_limit 6144, y_limit 8192.
module touch_serial_frame_decoder
    import tsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic        touching,
    output logic [15:0] x_pos,
    output logic [15:0] y_pos,
    output logic [9:0]  pressure,
    output logic [55:0] version_word
);

    logic        lock_reg;
    logic [15:0] xlim_reg, ylim_reg;
    logic        cfg_wr;
    logic        accept;
    logic        push, full, pop, head_valid;
    job_t        push_job, head_job;
    limits_t     limits;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= 1'b0;
            xlim_reg <= XLIMIT_RST;
            ylim_reg <= YLIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_LOCK:   lock_reg <= pwdata[0];
                REG_XLIMIT: xlim_reg <= pwdata[15:0];
                REG_YLIMIT: ylim_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LOCK:   prdata = {31'b0, lock_reg};
            REG_XLIMIT: prdata = {16'b0, xlim_reg};
            REG_YLIMIT: prdata = {16'b0, ylim_reg};
            default:    prdata = '0;
        endcase
    end

    assign limits.x_limit = xlim_reg;
    assign limits.y_limit = ylim_reg;

    // Front end takes a word whenever the queue has room
    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    tsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .rx_byte     (rx_byte),
        .lock_enable (lock_reg),
        .push        (push),
        .push_job    (push_job)
    );

    tsfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    tsfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .limits       (limits),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .touching     (touching),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .pressure     (pressure),
        .version_word (version_word)
    );

endmodule

// File: tb/testbench.sv
module testbench;
    import tsfd_pkg::*;

    // Command code the block ignores; the package names only the three it uses
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Traffic shaping
    localparam int BUSY_PCT  = 58;
    localparam int BOTH_PCT  = 22;
    localparam int unsigned PHASE_WORDS = 100;
    localparam int unsigned LOCK_WORDS  = 40;
    // Queue write plus output register, with a wide margin
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic        touching;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [9:0]  pressure;
        logic [55:0] version_word;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  command = CMD_BYTE;
    logic [7:0]  rx_byte = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  kind;
    logic        touching;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [9:0]  pressure;
    logic [55:0] version_word;

    // Decoder state as the testbench sees it
    logic        lock_cfg = 1'b0;
    logic [15:0] x_limit_cfg = XLIMIT_RST;
    logic [15:0] y_limit_cfg = YLIMIT_RST;
    int unsigned frame_pos = 0;
    logic [7:0]  frame_buf [FRAME_LEN];
    logic        pen_up = 1'b0;
    logic        version_armed = 1'b0;
    logic        idle_armed = 1'b0;

    report_t     expected_reports [$];
    report_t     head_report;
    int          fail_count = 0;
    int unsigned words_applied = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    touch_serial_frame_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .touching     (touching),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .pressure     (pressure),
        .version_word (version_word)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Works out the reports that one accepted word causes
    function automatic void decode_word(logic [1:0] cmd, logic [7:0] data);
        int unsigned ux;
        int unsigned uy;
        int unsigned up;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [9:0]  pres;
        logic        button;
        logic [55:0] word;
        case (cmd)
            CMD_VERSION: version_armed = 1'b1;
            CMD_IDLE:    idle_armed = 1'b1;
            CMD_BYTE:
            begin
                if (lock_cfg)
                    return;
                // idle ack swallows the byte before framing sees it
                if (idle_armed && data == IDLE_ACK)
                begin
                    idle_armed = 1'b0;
                    expected_reports.push_back(report_t'{KIND_IDLE, 1'b0, 16'd0, 16'd0,
                                                         10'd0, 56'd0});
                    return;
                end
                if (frame_pos == 0)
                begin
                    if (!data[7])
                        return;
                end
                else if (data[7])
                    frame_pos = 0;
                frame_buf[frame_pos] = data;
                frame_pos++;
                if (frame_pos != FRAME_LEN)
                    return;
                frame_pos = 0;

                // version capture takes the raw frame, no position decode
                if (version_armed && frame_buf[0] == VERSION_HEAD)
                begin
                    version_armed = 1'b0;
                    word = '0;
                    for (int i = 0; i < FRAME_LEN; i++)
                        word = {word[47:0], frame_buf[i]};
                    expected_reports.push_back(report_t'{KIND_VERSION, 1'b0, 16'd0, 16'd0,
                                                         10'd0, word});
                    return;
                end

                button = frame_buf[0][0];
                ux = (32'(frame_buf[1]) << 9) | (32'(frame_buf[2]) << 2)
                     | (32'(frame_buf[6]) >> 5);
                uy = (32'(frame_buf[3]) << 9) | (32'(frame_buf[4]) << 2)
                     | ((32'(frame_buf[6]) >> 3) & 32'h3);
                up = 32'(frame_buf[5]) | ((32'(frame_buf[6]) & 32'h7) << 7);
                raw_x = ux[15:0];
                raw_y = uy[15:0];
                pres  = up[9:0];
                if (raw_x > x_limit_cfg || raw_y > y_limit_cfg)
                    return;

                if (button && pres != 10'd0)
                begin
                    pen_up = 1'b0;
                    expected_reports.push_back(report_t'{KIND_POS, 1'b1, x_limit_cfg - raw_x,
                                                         y_limit_cfg - raw_y, pres, 56'd0});
                end
                else if (!button && pres == 10'd0)
                    expected_reports.push_back(report_t'{KIND_POS, 1'b0, x_limit_cfg - raw_x,
                                                         y_limit_cfg - raw_y, 10'd0, 56'd0});
                else if (button && pres == 10'd0 && !pen_up)
                begin
                    // one-shot pen lift
                    pen_up = 1'b1;
                    expected_reports.push_back(report_t'{KIND_POS, 1'b0, x_limit_cfg - raw_x,
                                                         y_limit_cfg - raw_y, 10'd0, 56'd0});
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string fname, logic [55:0] exp_v, logic [55:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("kind: expected no word, got %0h", kind);
                fail_count++;
            end
            else
            begin
                head_report = expected_reports.pop_front();
                check_field("kind", 56'(head_report.kind), 56'(kind));
                check_field("touching", 56'(head_report.touching), 56'(touching));
                check_field("x_pos", 56'(head_report.x_pos), 56'(x_pos));
                check_field("y_pos", 56'(head_report.y_pos), 56'(y_pos));
                check_field("pressure", 56'(head_report.pressure), 56'(pressure));
                check_field("version_word", head_report.version_word, version_word);
            end
        end
    end

    // Receiver backpressure
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    // Drives one word; returns at the edge that accepts it
    task automatic send_word(logic [1:0] cmd, logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        rx_byte    <= data;
        do
            @(posedge clk);
        while (!item_ready);
        words_applied++;
        decode_word(cmd, data);
    endtask

    // Packs a position into the seven-byte frame layout
    task automatic send_frame(logic [7:0] head, logic [15:0] x, logic [15:0] y,
                              logic [9:0] pres);
        logic [7:0] fb [FRAME_LEN];
        fb[0] = head;
        fb[1] = {1'b0, x[15:9]};
        fb[2] = {1'b0, x[8:2]};
        fb[3] = {1'b0, y[15:9]};
        fb[4] = {1'b0, y[8:2]};
        fb[5] = {1'b0, pres[6:0]};
        fb[6] = {1'b0, x[1:0], y[1:0], pres[9:7]};
        foreach (fb[i])
            send_word(CMD_BYTE, fb[i]);
    endtask

    // Drops valid, waits for all reports, then lets the back end settle
    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (reg_idx)
            REG_LOCK:   lock_cfg = value[0];
            REG_XLIMIT: x_limit_cfg = value[15:0];
            REG_YLIMIT: y_limit_cfg = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] pick_coord(logic [15:0] lim);
        case ($urandom_range(9))
            0: return 16'd0;
            1: return lim;
            2: return (lim == 16'hFFFF) ? lim : lim + 16'd1;
            3: return 16'($urandom);
            default: return 16'($urandom_range(lim));
        endcase
    endfunction

    function automatic logic [7:0] pick_head();
        case ($urandom_range(3))
            0: return 8'h81;
            1: return VERSION_HEAD;
            default: return 8'h80 | 8'($urandom);
        endcase
    endfunction

    // Mostly whole frames, plus arms, acks, ignored commands, noise and cut-off frames
    task automatic send_random_sequence();
        int unsigned pick;
        logic [9:0]  pres;
        pick = $urandom_range(99);
        if (pick < 62)
        begin
            case ($urandom_range(9))
                0, 1, 2: pres = 10'd0;
                3:       pres = 10'h3FF;
                default: pres = 10'($urandom);
            endcase
            send_frame(pick_head(), pick_coord(x_limit_cfg), pick_coord(y_limit_cfg), pres);
        end
        else if (pick < 70)
            send_word(CMD_VERSION, 8'($urandom));
        else if (pick < 75)
            send_word(CMD_IDLE, 8'($urandom));
        else if (pick < 80)
            send_word(CMD_BYTE, IDLE_ACK);
        else if (pick < 85)
            send_word(CMD_NONE, 8'($urandom));
        else if (pick < 92)
            send_word(CMD_BYTE, 8'($urandom));
        else
        begin
            send_word(CMD_BYTE, pick_head());
            repeat ($urandom_range(5))
                send_word(CMD_BYTE, {1'b0, 7'($urandom)});
        end
    endtask

    task automatic run_phase(logic lock, logic [15:0] xl, logic [15:0] yl,
                             int send_pct, int stall_in, int unsigned n_words);
        int unsigned start_count;
        wait_drained();
        write_reg(REG_LOCK, {31'd0, lock});
        write_reg(REG_XLIMIT, {16'd0, xl});
        write_reg(REG_YLIMIT, {16'd0, yl});
        send_idle_pct = send_pct;
        stall_pct     = stall_in;
        start_count   = words_applied;
        while (words_applied - start_count < n_words)
            send_random_sequence();
    endtask

    // Noise, restart inside a frame, touch-down, pen lift
    task automatic test_framing();
        send_word(CMD_BYTE, 8'h00);
        send_word(CMD_BYTE, 8'h81);
        send_word(CMD_BYTE, 8'h7F);
        send_word(CMD_BYTE, 8'h7F);
        send_frame(8'h81, XLIMIT_RST, 16'd0, 10'h3FF);
        send_frame(8'hFF, 16'd0, YLIMIT_RST, 10'd0);
    endtask

    // Ignored command, idle ack, version capture
    task automatic test_commands();
        send_word(CMD_NONE, 8'hFF);
        send_word(CMD_IDLE, 8'h00);
        send_word(CMD_BYTE, IDLE_ACK);
        send_word(CMD_VERSION, 8'hFF);
        send_frame(VERSION_HEAD, 16'hFFFF, 16'hFFFF, 10'h3FF);
    endtask

    task automatic test_limits();
        run_phase(1'b0, 16'd0, 16'd0, BUSY_PCT, 0, PHASE_WORDS);
        run_phase(1'b0, 16'hFFFF, 16'hFFFF, 0, BUSY_PCT, PHASE_WORDS);
        run_phase(1'b0, 16'hFFFF, 16'd0, BOTH_PCT, BOTH_PCT, PHASE_WORDS);
    endtask

    // Bytes dropped while locked; arms still take effect
    task automatic test_lock();
        run_phase(1'b1, 16'($urandom), 16'($urandom), BOTH_PCT, BOTH_PCT, LOCK_WORDS);
    endtask

    task automatic test_random_traffic();
        run_phase(1'b0, XLIMIT_RST, YLIMIT_RST, 0, 0, PHASE_WORDS);
        run_phase(1'b0, 16'($urandom), 16'($urandom), BUSY_PCT, 0, PHASE_WORDS);
        run_phase(1'b0, 16'($urandom_range(1023)), 16'hFFFF, 0, BUSY_PCT, PHASE_WORDS);
        run_phase(1'b0, 16'($urandom), 16'($urandom), BOTH_PCT, BOTH_PCT, PHASE_WORDS);
        run_phase(1'b0, 16'($urandom), 16'($urandom), 0, 0, PHASE_WORDS);
    endtask

    // Main sequence
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_framing();
        test_commands();
        test_limits();
        test_lock();
        test_random_traffic();

        wait_drained();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tsfd_pkg.sv
hw/rtl/tsfd_front.sv
hw/rtl/tsfd_queue.sv
hw/rtl/tsfd_back.sv
hw/rtl/touch_serial_frame_decoder.sv
tb/testbench.sv
